### design/ordered_list_deque_engine_defines.svh
// Assertion macros used by the checker of the deque engine.
`ifndef ORDERED_LIST_DEQUE_ENGINE_DEFINES_SVH
`define ORDERED_LIST_DEQUE_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLDE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OLDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/olde_pkg.sv
package olde_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 6;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 7;

  typedef enum logic [1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_REAR  = 2'd1,
    OP_DELETE    = 2'd2,
    OP_SEARCH    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found_position;
    logic [COUNT_W-1:0]  count;
  } out_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_req;
    logic    ins_front;
    logic    ins_rear;
    logic    del_head;
    logic    count_dec;
    logic    idx_from_pos;
    logic    idx_clear;
    logic    shift_rd;
    logic    shift_wr;
    logic    srch_step;
    logic    set_result;
    logic    found_take;
    status_t res_status;
    logic    out_load;
  } olde_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic pos_bad;
    logic pos_zero;
    logic shift_more;
    logic srch_hit;
    logic srch_end;
    logic out_busy;
  } olde_sts_t;

endpackage

### design/olde_datapath.sv
module olde_datapath #(
  parameter int CAPACITY = olde_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  olde_pkg::in_req_t   in_data,
  input  olde_pkg::olde_cmd_t cmd,
  output olde_pkg::olde_sts_t sts,
  output logic                out_valid,
  input  logic                out_stall,
  output olde_pkg::out_rsp_t  out_data
);
  import olde_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = CNT_W + POS_W;

  logic [VALUE_W-1:0] mem [CAPACITY];

  in_req_t             req_r;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [CNT_W-1:0]    cmp_idx_r;
  logic [VALUE_W-1:0]  rdata_r;
  status_t             res_status_r;
  logic [POS_W-1:0]    res_found_r;
  logic                out_valid_r, out_valid_nxt;
  out_rsp_t            out_data_r;

  logic [CNT_W-1:0]    idx_inc;
  logic                idx_lt_cnt;
  logic [CNT_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    raddr, waddr, head_dec;
  logic [VALUE_W-1:0]  wdata;
  logic                re, we;

  // Ring slot of a logical entry index relative to the head.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] idx);
    logic [SUM_W-1:0] s;
    s = SUM_W'(head) + SUM_W'(idx);
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  assign idx_inc    = idx_r + CNT_W'(1);
  assign idx_lt_cnt = idx_r < count_r;
  assign head_dec   = (head_r == '0) ? IDX_W'(CAPACITY - 1) : head_r - IDX_W'(1);

  assign rd_idx = cmd.shift_rd ? idx_inc : idx_r;
  assign raddr  = slot_of(head_r, rd_idx);
  assign re     = cmd.shift_rd | (cmd.srch_step & idx_lt_cnt);

  always_comb begin
    if (cmd.ins_front) begin
      waddr = head_dec;
    end else if (cmd.ins_rear) begin
      waddr = slot_of(head_r, count_r);
    end else begin
      waddr = slot_of(head_r, idx_r);
    end
  end

  assign wdata = cmd.shift_wr ? rdata_r : $unsigned(req_r.value);
  assign we    = cmd.ins_front | cmd.ins_rear | cmd.shift_wr;

  always_comb begin
    head_nxt = head_r;
    if (cmd.ins_front) begin
      head_nxt = head_dec;
    end else if (cmd.del_head) begin
      head_nxt = slot_of(head_r, CNT_W'(1));
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins_front | cmd.ins_rear) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.del_head | cmd.count_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_from_pos) begin
      idx_nxt = CNT_W'(req_r.position);
    end else if (cmd.idx_clear) begin
      idx_nxt = '0;
    end else if (cmd.shift_wr | (cmd.srch_step & idx_lt_cnt)) begin
      idx_nxt = idx_inc;
    end
  end

  assign cmp_vld_nxt   = cmd.srch_step & idx_lt_cnt;
  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
    end
    if (cmp_vld_nxt) begin
      cmp_idx_r <= idx_r;
    end
    if (cmd.set_result) begin
      res_status_r <= cmd.res_status;
      res_found_r  <= cmd.found_take ? POS_W'(cmp_idx_r) : '0;
    end
    if (cmd.out_load) begin
      out_data_r.status         <= res_status_r;
      out_data_r.found_position <= res_found_r;
      out_data_r.count          <= COUNT_W'(count_r);
    end
  end

  // Entry store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign sts.op         = req_r.op;
  assign sts.full       = count_r == CNT_W'(CAPACITY);
  assign sts.empty      = count_r == '0;
  assign sts.pos_bad    = CMP_W'(req_r.position) >= CMP_W'(count_r);
  assign sts.pos_zero   = req_r.position == '0;
  assign sts.shift_more = (SUM_W'(idx_r) + SUM_W'(1)) < SUM_W'(count_r);
  assign sts.srch_hit   = cmp_vld_r && (rdata_r == $unsigned(req_r.value));
  assign sts.srch_end   = !cmp_vld_r && !idx_lt_cnt;
  assign sts.out_busy   = out_valid_r & out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/olde_ctrl.sv
module olde_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output olde_pkg::olde_cmd_t cmd,
  input  olde_pkg::olde_sts_t sts
);
  import olde_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECIDE   = 6'b000010,
    S_SHIFT_RD = 6'b000100,
    S_SHIFT_WR = 6'b001000,
    S_SRCH     = 6'b010000,
    S_RESULT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.set_result = 1'b1;
        cmd.res_status = ST_OK;
        state_nxt      = S_RESULT;
        case (sts.op)
          OP_INS_FRONT, OP_INS_REAR: begin
            if (sts.full) begin
              cmd.res_status = ST_FULL;
            end else if (sts.op == OP_INS_FRONT) begin
              cmd.ins_front = 1'b1;
            end else begin
              cmd.ins_rear = 1'b1;
            end
          end
          OP_DELETE: begin
            if (sts.empty) begin
              cmd.res_status = ST_EMPTY;
            end else if (sts.pos_bad) begin
              cmd.res_status = ST_BADPOS;
            end else if (sts.pos_zero) begin
              cmd.del_head = 1'b1;
            end else begin
              cmd.set_result   = 1'b0;
              cmd.idx_from_pos = 1'b1;
              state_nxt        = S_SHIFT_RD;
            end
          end
          OP_SEARCH: begin
            if (sts.empty) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.set_result = 1'b0;
              cmd.idx_clear  = 1'b1;
              state_nxt      = S_SRCH;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SHIFT_RD: begin
        if (sts.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end else begin
          cmd.count_dec  = 1'b1;
          cmd.set_result = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt      = S_RESULT;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_SRCH: begin
        if (sts.srch_hit) begin
          cmd.set_result = 1'b1;
          cmd.found_take = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt      = S_RESULT;
        end else if (sts.srch_end) begin
          cmd.set_result = 1'b1;
          cmd.res_status = ST_NOTFOUND;
          state_nxt      = S_RESULT;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/ordered_list_deque_engine.sv
// Channel  | Direction | Handshake         | Payload
// ---------+-----------+-------------------+--------------------------------------
// in_      | input     | in_valid/in_stall | in_data: op, value, position
// out_     | output    | out_valid/out_stall | out_data: status, found_position, count
//
// One request is worked on at a time. Inserts, head deletes and every refused
// or empty case go from decode straight to the result state. A delete at
// nonzero position p moves each entry behind p one place toward the head;
// each moved entry needs one read and one write on the entry store. A search
// reads the entries from the head, one store read per cycle, until a match or
// the end of the list. Reset clears the head, the count and all control; the
// entry store needs no clearing pass. A stalled result waits in the output
// register while the next request is already accepted and worked on.
module ordered_list_deque_engine #(
  parameter int CAPACITY = olde_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  olde_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output olde_pkg::out_rsp_t out_data
);
  import olde_pkg::*;

  // Commands and status between the sequencer and the store datapath.
  olde_cmd_t cmd;
  olde_sts_t sts;

  // The controller walks each request through decode, the shift loop of a
  // positional delete or the scan of a search, and the hand-off to the
  // output register.
  olde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath holds the ring store, the head and count registers, the
  // walk index, and the result and output registers.
  olde_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### design/olde_checker.sv
`include "ordered_list_deque_engine_defines.svh"

module olde_checker #(
  parameter int CAPACITY = olde_pkg::CAPACITY_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input olde_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input olde_pkg::out_rsp_t out_data
);
  import olde_pkg::*;

  // A result that is not taken stays offered.
  `OLDE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
    "result dropped while stalled")

  // Requests are worked on one at a time, so acceptance closes the input.
  `OLDE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall,
    "second request accepted while one is in flight")

  // A refused insert only happens with the store full.
  `OLDE_ASSERT_NOW(a_full_count, clk, rst_n, out_valid && out_data.status == ST_FULL,
    out_data.count == COUNT_W'(CAPACITY), "full status with store not full")

  // An empty status reports no entries held.
  `OLDE_ASSERT_NOW(a_empty_count, clk, rst_n, out_valid && out_data.status == ST_EMPTY,
    out_data.count == '0, "empty status with entries held")

  // Only a successful search reports a nonzero position.
  `OLDE_ASSERT_NOW(a_found_zero, clk, rst_n, out_valid && out_data.status != ST_OK,
    out_data.found_position == '0, "found position set on a failed request")

endmodule

bind ordered_list_deque_engine olde_checker #(.CAPACITY(CAPACITY)) u_olde_checker (.*);
